// ===== hdl/hbp_pkg.sv =====
// constants and types for the huffman table bit packer
// self-contained, no dependencies; used by huffman_table_bit_packer_top

package hbp_pkg;

  // longest code word the table accepts
  localparam int unsigned MAX_CODE_LEN = 32;

  // payload field widths
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned TAIL_W = 4;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned NUM_SYM = 1 << SYM_W;

  // pending tail: up to 7 bits
  localparam int unsigned PEND_W = 7;
  localparam int unsigned PCNT_W = 3;

  // accumulator holds pending tail plus one full code word
  localparam int unsigned ACC_W     = MAX_CODE_LEN + PEND_W;
  localparam int unsigned TOT_W     = $clog2(ACC_W + 1);
  localparam int unsigned MAX_BYTES = (MAX_CODE_LEN + 7) / 8;
  localparam int unsigned WORD_W    = MAX_BYTES * 8;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int unsigned SHF_W     = $clog2(WORD_W + 1);

  // tail_bits value for a full byte or a flush without tail
  localparam logic [TAIL_W-1:0] TAIL_FULL = TAIL_W'(8);

  // stream padding widths
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

endpackage

// ===== hdl/huffman_table_bit_packer_top.sv =====
// huffman encoder with a code table loaded through the input stream
// depends on hbp_pkg
//
//  channel  dir  transfer                tdata                          tuser / tlast
//  s_axis   in   load, encode or flush   symbol, code_bits, code_length kind / -
//  m_axis   out  packed byte or trailer  out_byte, tail_bits            byte_valid, is_trailer / last
//
// one input item per cycle while each item makes at most one result and the sink keeps up
// an encode that completes n bytes (up to 4) holds the result register until all n are sent,
// so the next item with results waits for it even when the sink is always ready
// lookup registered into stage 1 at acceptance, packing done from stage 1, first result valid
// once the result register takes it; loads and items with no result never wait on the output side
// reset clears the pending tail, the entry valid bits, the stage 1 valid bit and the result count

module huffman_table_bit_packer_top
  import hbp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]   s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] out_byte, [11:8] tail_bits, [15:12] zero
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // [0] byte_valid, [1] is_trailer
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  // ------------------------------------------------------------------
  // input fields
  // ------------------------------------------------------------------
  logic              in_xfer;
  logic [SYM_W-1:0]  in_sym;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  kind_e             in_kind;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_sym  = s_axis_tdata[SYM_W-1:0];
  assign in_code = s_axis_tdata[SYM_W +: CODE_W];
  assign in_len  = s_axis_tdata[SYM_W+CODE_W +: LEN_W];
  assign in_kind = kind_e'(s_axis_tuser);

  // ------------------------------------------------------------------
  // code table: code and length memories, valid bit per symbol in flops
  // a load is written at acceptance, so a following encode sees it
  // ------------------------------------------------------------------
  logic [CODE_W-1:0]  code_mem [NUM_SYM];
  logic [LEN_W-1:0]   len_mem  [NUM_SYM];
  logic [NUM_SYM-1:0] ent_vld_q;

  logic              load_wr;
  logic [CODE_W-1:0] load_code;

  // first entry wins; bad lengths leave the symbol without an entry
  assign load_wr = in_xfer && (in_kind == KIND_LOAD) && (in_len != '0) &&
                   (in_len <= LEN_W'(MAX_CODE_LEN)) && !ent_vld_q[in_sym];
  // keep only the low code_length bits
  assign load_code = in_code & CODE_W'((64'd1 << in_len) - 64'd1);

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      code_mem[in_sym] <= load_code;
      len_mem[in_sym]  <= in_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (load_wr) begin
      ent_vld_q[in_sym] <= 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: registered item with its table lookup
  // ------------------------------------------------------------------
  logic              s1_vld_q;
  kind_e             s1_kind_q;
  logic              s1_hit_q;
  logic [CODE_W-1:0] s1_code_q;
  logic [LEN_W-1:0]  s1_len_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_code_q <= code_mem[in_sym];
      s1_len_q  <= len_mem[in_sym];
      s1_kind_q <= in_kind;
      s1_hit_q  <= ent_vld_q[in_sym];
    end
  end

  // pending tail bits, right aligned
  logic [PEND_W-1:0] pend_bits_q, pend_bits_d;
  logic [PCNT_W-1:0] pend_cnt_q,  pend_cnt_d;

  // packing of one encode
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  enc_nbytes;
  logic [2:0]        rem;
  logic [ACC_W-1:0]  emitted;
  logic [SHF_W-1:0]  enc_shamt;
  logic [WORD_W-1:0] enc_word;
  logic [PEND_W-1:0] enc_pend;
  logic [BYTE_W-1:0] flush_byte;

  assign acc        = (ACC_W'(pend_bits_q) << s1_len_q) | ACC_W'(s1_code_q);
  assign total      = TOT_W'(pend_cnt_q) + TOT_W'(s1_len_q);
  assign enc_nbytes = CNT_W'(total >> 3);
  assign rem        = total[2:0];
  // completed bytes right aligned, then moved to the top of the word
  assign emitted    = acc >> rem;
  assign enc_shamt  = SHF_W'(WORD_W) - (SHF_W'(enc_nbytes) << 3);
  assign enc_word   = WORD_W'(emitted) << enc_shamt;
  assign enc_pend   = PEND_W'(acc) & PEND_W'((8'd1 << rem) - 8'd1);

  // tail zero padded, earliest bit in bit 7
  assign flush_byte = BYTE_W'({pend_bits_q, 1'b0} << (3'd7 - pend_cnt_q));

  // what stage 1 hands to the result register
  logic [CNT_W-1:0]  s1_nres;
  logic [WORD_W-1:0] s1_word;
  logic              s1_trl;

  always_comb begin
    s1_nres     = '0;
    s1_word     = enc_word;
    s1_trl      = 1'b0;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    unique case (s1_kind_q)
      KIND_ENCODE: begin
        // symbols without an entry change nothing
        if (s1_hit_q) begin
          s1_nres     = enc_nbytes;
          pend_bits_d = enc_pend;
          pend_cnt_d  = rem;
        end
      end
      KIND_FLUSH: begin
        s1_nres     = CNT_W'(1);
        s1_word     = WORD_W'(flush_byte) << (WORD_W - BYTE_W);
        s1_trl      = 1'b1;
        pend_bits_d = '0;
        pend_cnt_d  = '0;
      end
      default: begin
        // loads were done at acceptance; kind 3 is dropped
      end
    endcase
  end

  // ------------------------------------------------------------------
  // result register: bytes of one item, shifted out from the top
  // ------------------------------------------------------------------
  logic [CNT_W-1:0]  grp_cnt_q;
  logic [WORD_W-1:0] grp_word_q;
  logic              grp_trl_q;
  logic              grp_bvld_q;
  logic [TAIL_W-1:0] grp_tail_q;

  logic out_xfer;
  logic grp_free;
  logic s1_take;

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  // free now, or its last transfer happens this cycle
  assign grp_free = (grp_cnt_q == '0) || (out_xfer && (grp_cnt_q == CNT_W'(1)));
  // items with no result leave stage 1 without waiting
  assign s1_take  = s1_vld_q && ((s1_nres == '0) || grp_free);

  assign s_axis_tready = !s1_vld_q || s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
      end else if (s1_take) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_take) begin
        pend_bits_q <= pend_bits_d;
        pend_cnt_q  <= pend_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q <= '0;
    end else if (s1_take && (s1_nres != '0)) begin
      grp_cnt_q <= s1_nres;
    end else if (out_xfer) begin
      grp_cnt_q <= grp_cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take && (s1_nres != '0)) begin
      grp_word_q <= s1_word;
      grp_trl_q  <= s1_trl;
      // flush without tail: no data, tail count of a full byte
      grp_bvld_q <= !s1_trl || (pend_cnt_q != '0);
      grp_tail_q <= (s1_trl && (pend_cnt_q != '0)) ? TAIL_W'(pend_cnt_q) : TAIL_FULL;
    end else if (out_xfer) begin
      grp_word_q <= grp_word_q << BYTE_W;
    end
  end

  assign m_axis_tvalid = (grp_cnt_q != '0);
  assign m_axis_tlast  = (grp_cnt_q == CNT_W'(1));
  assign m_axis_tdata  = M_DATA_W'({grp_tail_q, grp_word_q[WORD_W-1 -: BYTE_W]});
  assign m_axis_tuser  = {grp_trl_q, grp_bvld_q};

`ifndef SYNTHESIS
  // never more results queued than one code word can complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= CNT_W'(MAX_BYTES))
    else $error("result count exceeds bytes per code");

  // bits above the pending count stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_bits_q >> pend_cnt_q) == '0)
    else $error("stale bits above pending tail");

  // a flush trailer is always a single result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && grp_trl_q) |-> m_axis_tlast)
    else $error("trailer group with more than one result");

  // results are never loaded over a group still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && (s1_nres != '0)) |-> grp_free)
    else $error("result register overwritten");

  // a stalled result keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(grp_word_q))
    else $error("pending result changed under stall");
`endif

endmodule
